// ----- src/assert_macros.svh -----
// Assertion macros shared by the wait list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion with asynchronous active-low reset disable.
`define PWL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define PWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWL_ASSERT(lbl, clk, rst_n, prop, msg)
`define PWL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/pwl_pkg.sv -----
// Types and codes for the priority wait list.
package pwl_pkg;

	localparam int unsigned ID_W   = 8;
	localparam int unsigned PRIO_W = 8;
	localparam int unsigned OCC_W  = 5;

	// Function codes on the func port
	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_POP    = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Operation broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_POP
	} cell_op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   key;
	} cell_ctrl_t;

endpackage

// ----- src/pwl_cell.sv -----
// One slot of the sorted list: holds an entry and shifts with its neighbors.
module pwl_cell (
	input  logic              clk,
	input  pwl_pkg::cell_ctrl_t ctrl,
	input  logic              valid,
	input  logic              left_ge,
	input  pwl_pkg::entry_t   left_entry,
	input  pwl_pkg::entry_t   right_entry,
	input  logic              seen_in,
	output logic              ge_out,
	output logic              seen_out,
	output pwl_pkg::entry_t   entry
);
	import pwl_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	logic   hit;

	// Compare against the broadcast key
	assign ge_out   = valid && (entry_q.prio >= ctrl.key.prio);
	assign hit      = valid && (entry_q.id == ctrl.key.id);
	assign seen_out = seen_in || hit;
	assign entry    = entry_q;

	// Next slot contents
	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (!ge_out) begin
					entry_d = left_ge ? ctrl.key : left_entry;
				end
			end
			CELL_REMOVE: begin
				if (seen_out) begin
					entry_d = right_entry;
				end
			end
			CELL_POP: entry_d = right_entry;
			CELL_HOLD: entry_d = entry_q;
			default: entry_d = entry_q;
		endcase
	end

	// Slot storage, no reset: read only below the fill count
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ----- src/priority_waitlist_with_remove.sv -----
// The result strobe (done) is registered and rises in the cycle after start is accepted.
// Throughput: one operation per cycle; busy stays low, since every cell of the
// shift chain compares against the broadcast key and moves in the same cycle.
// Reset clears the fill count and the strobe; slot contents stay undefined and
// are never read before they are written. The receiver cannot stall results.
module priority_waitlist_with_remove #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 func,
	input  logic [pwl_pkg::ID_W-1:0]   requester_id,
	input  logic [pwl_pkg::PRIO_W-1:0] priority_req,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [pwl_pkg::ID_W-1:0]   popped_id,
	output logic [pwl_pkg::PRIO_W-1:0] popped_priority,
	output logic [pwl_pkg::OCC_W-1:0]  occupancy
);
	import pwl_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             done_q;
	status_t          status_q;
	status_t          status_d;
	entry_t           popped_q;
	entry_t           popped_d;
	logic [OCC_W-1:0] occ_q;

	cell_ctrl_t ctrl;
	func_t      fn;
	logic       accept;
	logic       full;
	logic       empty;

	logic   ge    [LIST_DEPTH];
	logic   seen  [LIST_DEPTH];
	entry_t slots [LIST_DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign fn     = func_t'(func);
	assign full   = (count_q == CNT_W'(LIST_DEPTH));
	assign empty  = (count_q == '0);

	// Decode the operation for the cell chain
	always_comb begin
		ctrl.key.id   = requester_id;
		ctrl.key.prio = priority_req;
		ctrl.op       = CELL_HOLD;
		if (accept) begin
			unique case (fn)
				FN_INSERT: ctrl.op = full ? CELL_HOLD : CELL_INSERT;
				FN_REMOVE: ctrl.op = CELL_REMOVE;
				FN_POP:    ctrl.op = empty ? CELL_HOLD : CELL_POP;
				FN_NOP:    ctrl.op = CELL_HOLD;
				default:   ctrl.op = CELL_HOLD;
			endcase
		end
	end

	// Chain of cells
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic   valid;
		logic   left_ge;
		logic   seen_in;
		entry_t left_entry;
		entry_t right_entry;

		assign valid = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign seen_in    = 1'b0;
			assign left_entry = '0;
		end else begin : g_body
			assign left_ge    = ge[i-1];
			assign seen_in    = seen[i-1];
			assign left_entry = slots[i-1];
		end

		if (i == LIST_DEPTH - 1) begin : g_tail
			assign right_entry = '0;
		end else begin : g_next
			assign right_entry = slots[i+1];
		end

		pwl_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (valid),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.seen_in     (seen_in),
			.ge_out      (ge[i]),
			.seen_out    (seen[i]),
			.entry       (slots[i])
		);
	end

	// Status, popped entry and next count
	always_comb begin
		status_d = ST_OK;
		popped_d = '0;
		count_d  = count_q;
		unique case (fn)
			FN_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			FN_REMOVE: begin
				if (seen[LIST_DEPTH-1]) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			FN_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					popped_d = slots[0];
					count_d  = count_q - CNT_W'(1);
				end
			end
			FN_NOP: status_d = ST_OK;
			default: status_d = ST_OK;
		endcase
	end

	// Fill count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			popped_q <= popped_d;
			occ_q    <= OCC_W'(count_d);
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign popped_id       = popped_q.id;
	assign popped_priority = popped_q.prio;
	assign occupancy       = occ_q;

	`PWL_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(LIST_DEPTH), "count over depth")
	`PWL_ASSERT(a_strobe, clk, arst_n, accept |=> done, "no result beat after accept")
	`PWL_ASSERT(a_full_drop, clk, arst_n, (accept && fn == FN_INSERT && !full) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not grow list")
	`PWL_ASSERT(a_pop_empty, clk, arst_n, (done && status_q == ST_EMPTY) |-> (count_q == '0), "empty status on nonempty list")

endmodule
